@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define AGB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define AGB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/agbkf_pkg.sv @@
package agbkf_pkg;

  localparam int COV_BITS   = 30;
  localparam int DT_BITS    = 16;
  localparam int NOISE_BITS = 16;
  localparam int NOISE_SH   = COV_BITS - NOISE_BITS;
  localparam int DIV_STEPS  = 62;
  localparam int CNT_W      = 6;
  localparam int SUM_W      = 68;

  localparam logic [NOISE_BITS-1:0] APN_RESET = 16'd393;
  localparam logic [NOISE_BITS-1:0] BPN_RESET = 16'd655;
  localparam logic [NOISE_BITS-1:0] MN_RESET  = 16'd1311;

  localparam logic [1:0] REG_APN = 2'd0;
  localparam logic [1:0] REG_BPN = 2'd1;
  localparam logic [1:0] REG_MN  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_DIV_SETUP,
    ST_DIV,
    ST_DIV_DONE,
    ST_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_ANG_P,
    OP_AA_P,
    OP_AB_P,
    OP_BA_P,
    OP_BB_P,
    OP_AA_C,
    OP_AB_C,
    OP_BA_C,
    OP_BB_C,
    OP_ANG_C,
    OP_BIAS_C
  } op_t;

  function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] x);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(64'sh7FFF_FFFF);
    lo = -SUM_W'(64'sh8000_0000);
    if (x > hi) begin
      return 32'sh7FFF_FFFF;
    end else if (x < lo) begin
      return 32'sh8000_0000;
    end
    return x[31:0];
  endfunction

endpackage

@@ rtl/angle_gyro_bias_kalman_filter.sv @@
// Channel | Handshake            | Beat contents
// in      | in_valid / in_stall  | angle_meas, gyro_rate, time_step
// out     | out_valid / out_stall| angle_est, rate_est
// cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
// A beat runs from accept to the next accept through eleven multiply/accumulate steps
// (a multiply state and an accumulate state each) on one shared 34x33 multiplier, two
// restoring divisions of 62 quotient bits (one quotient bit a cycle), each with a setup
// and a finishing state around it, one output state and the idle state.
// rst is synchronous, active high; it restores the filter state and the noise registers.
// in_stall stays high from accept until the result sits in the output register;
// a stalled output holds the block in its final state until the previous beat leaves.
`include "assert_macros.svh"

module angle_gyro_bias_kalman_filter (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [24:0]  angle_meas,
  input  logic signed [27:0]  gyro_rate,
  input  logic [15:0]         time_step,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  angle_est,
  output logic signed [31:0]  rate_est,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  localparam int SW = agbkf_pkg::SUM_W;

  agbkf_pkg::state_t state, state_next;
  agbkf_pkg::op_t    op;

  // Noise settings
  logic [15:0] apn, bpn, mn;

  // Filter state
  logic signed [31:0] angle, bias, cov_aa, cov_ab, cov_ba, cov_bb;

  // Captured sample
  logic signed [24:0] meas;
  logic signed [27:0] gyro;
  logic [15:0]        dt;

  // Gains and correction operands
  logic signed [31:0] k0, k1, e32, t0, t1;

  // Shared multiplier
  logic signed [33:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [66:0] prod;
  logic signed [31:0] acc_base;
  logic               acc_sh30;
  logic               acc_sub;
  logic signed [SW-1:0] rnd;
  logic signed [SW-1:0] acc_sum;
  logic signed [31:0]   acc_res;

  // Divider
  logic                         div_sel;
  logic [agbkf_pkg::CNT_W-1:0]  div_cnt;
  logic [33:0]                  div_rem;
  logic [33:0]                  div_den;
  logic [61:0]                  div_dvd;
  logic [61:0]                  div_q;
  logic                         div_neg;
  logic [34:0]                  div_r2;
  logic signed [33:0]           var_s;
  logic signed [31:0]           div_num;
  logic [31:0]                  num_mag;
  logic signed [SW-1:0]         q_signed;
  logic signed [31:0]           gain;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != agbkf_pkg::ST_IDLE);

  // Operand selection for the current step
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    acc_base = '0;
    acc_sh30 = 1'b0;
    acc_sub  = 1'b0;
    unique case (op)
      agbkf_pkg::OP_ANG_P: begin
        mul_a    = 34'(gyro) - 34'(bias);
        mul_b    = $signed({17'd0, dt});
        acc_base = angle;
      end
      agbkf_pkg::OP_AA_P: begin
        mul_a    = $signed({4'd0, apn, 14'd0}) - 34'(cov_ab) - 34'(cov_ba);
        mul_b    = $signed({17'd0, dt});
        acc_base = cov_aa;
      end
      agbkf_pkg::OP_AB_P: begin
        mul_a    = -34'(cov_bb);
        mul_b    = $signed({17'd0, dt});
        acc_base = cov_ab;
      end
      agbkf_pkg::OP_BA_P: begin
        mul_a    = -34'(cov_bb);
        mul_b    = $signed({17'd0, dt});
        acc_base = cov_ba;
      end
      agbkf_pkg::OP_BB_P: begin
        mul_a    = $signed({4'd0, bpn, 14'd0});
        mul_b    = $signed({17'd0, dt});
        acc_base = cov_bb;
      end
      agbkf_pkg::OP_AA_C: begin
        mul_a = 34'(k0); mul_b = 33'(t0); acc_base = cov_aa;
        acc_sh30 = 1'b1; acc_sub = 1'b1;
      end
      agbkf_pkg::OP_AB_C: begin
        mul_a = 34'(k0); mul_b = 33'(t1); acc_base = cov_ab;
        acc_sh30 = 1'b1; acc_sub = 1'b1;
      end
      agbkf_pkg::OP_BA_C: begin
        mul_a = 34'(k1); mul_b = 33'(t0); acc_base = cov_ba;
        acc_sh30 = 1'b1; acc_sub = 1'b1;
      end
      agbkf_pkg::OP_BB_C: begin
        mul_a = 34'(k1); mul_b = 33'(t1); acc_base = cov_bb;
        acc_sh30 = 1'b1; acc_sub = 1'b1;
      end
      agbkf_pkg::OP_ANG_C: begin
        mul_a = 34'(k0); mul_b = 33'(e32); acc_base = angle;
        acc_sh30 = 1'b1;
      end
      agbkf_pkg::OP_BIAS_C: begin
        mul_a = 34'(k1); mul_b = 33'(e32); acc_base = bias;
        acc_sh30 = 1'b1;
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  // Round half up, then add or subtract into the base and saturate
  always_comb begin
    if (acc_sh30) begin
      rnd = (SW'(prod) + SW'(68'sd536870912)) >>> agbkf_pkg::COV_BITS;
    end else begin
      rnd = (SW'(prod) + SW'(68'sd32768)) >>> agbkf_pkg::DT_BITS;
    end
    acc_sum = acc_sub ? (SW'(acc_base) - rnd) : (SW'(acc_base) + rnd);
    acc_res = agbkf_pkg::sat32(acc_sum);
  end

  // Divider datapath
  always_comb begin
    var_s   = $signed({4'd0, mn, 14'd0}) + 34'(cov_aa);
    div_num = div_sel ? cov_ba : cov_aa;
    num_mag = div_num[31] ? (32'd0 - 32'(div_num)) : 32'(div_num);
    div_r2  = {div_rem, div_dvd[61]};
    q_signed = div_neg ? -$signed({6'd0, div_q}) : $signed({6'd0, div_q});
    gain     = agbkf_pkg::sat32(q_signed);
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= agbkf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      agbkf_pkg::ST_IDLE: begin
        if (in_valid) state_next = agbkf_pkg::ST_MUL;
      end
      agbkf_pkg::ST_MUL: begin
        state_next = agbkf_pkg::ST_ACC;
      end
      agbkf_pkg::ST_ACC: begin
        priority if (op == agbkf_pkg::OP_BB_P) begin
          state_next = agbkf_pkg::ST_DIV_SETUP;
        end else if (op == agbkf_pkg::OP_BIAS_C) begin
          state_next = agbkf_pkg::ST_OUT;
        end else begin
          state_next = agbkf_pkg::ST_MUL;
        end
      end
      agbkf_pkg::ST_DIV_SETUP: begin
        state_next = (var_s > 34'sd0) ? agbkf_pkg::ST_DIV : agbkf_pkg::ST_DIV_DONE;
      end
      agbkf_pkg::ST_DIV: begin
        if (div_cnt == agbkf_pkg::CNT_W'(agbkf_pkg::DIV_STEPS - 1)) begin
          state_next = agbkf_pkg::ST_DIV_DONE;
        end
      end
      agbkf_pkg::ST_DIV_DONE: begin
        state_next = div_sel ? agbkf_pkg::ST_MUL : agbkf_pkg::ST_DIV_SETUP;
      end
      agbkf_pkg::ST_OUT: begin
        if (!out_valid || !out_stall) state_next = agbkf_pkg::ST_IDLE;
      end
      default: begin
        state_next = agbkf_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers: step index, divider select and count, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      op        <= agbkf_pkg::OP_ANG_P;
      div_sel   <= 1'b0;
      div_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      // load a new beat, or drop the current one once taken
      if (state == agbkf_pkg::ST_OUT && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        agbkf_pkg::ST_IDLE: begin
          op      <= agbkf_pkg::OP_ANG_P;
          div_sel <= 1'b0;
        end
        agbkf_pkg::ST_ACC: begin
          if (op != agbkf_pkg::OP_BB_P && op != agbkf_pkg::OP_BIAS_C) begin
            op <= agbkf_pkg::op_t'(op + 4'd1);
          end
        end
        agbkf_pkg::ST_DIV_SETUP: begin
          div_cnt <= '0;
        end
        agbkf_pkg::ST_DIV: begin
          div_cnt <= div_cnt + agbkf_pkg::CNT_W'(1);
        end
        agbkf_pkg::ST_DIV_DONE: begin
          div_cnt <= '0;
          if (div_sel) begin
            op <= agbkf_pkg::OP_AA_C;
          end
          div_sel <= 1'b1;
        end
        default: begin
          div_cnt <= div_cnt;
        end
      endcase
    end
  end

  // Noise settings and filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      apn    <= agbkf_pkg::APN_RESET;
      bpn    <= agbkf_pkg::BPN_RESET;
      mn     <= agbkf_pkg::MN_RESET;
      angle  <= '0;
      bias   <= '0;
      cov_aa <= 32'sh4000_0000;
      cov_ab <= '0;
      cov_ba <= '0;
      cov_bb <= 32'sh4000_0000;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          agbkf_pkg::REG_APN: apn <= cfg_data;
          agbkf_pkg::REG_BPN: bpn <= cfg_data;
          agbkf_pkg::REG_MN:  mn  <= cfg_data;
          default: ;
        endcase
      end
      if (state == agbkf_pkg::ST_ACC) begin
        unique case (op)
          agbkf_pkg::OP_ANG_P, agbkf_pkg::OP_ANG_C: angle  <= acc_res;
          agbkf_pkg::OP_AA_P,  agbkf_pkg::OP_AA_C:  cov_aa <= acc_res;
          agbkf_pkg::OP_AB_P,  agbkf_pkg::OP_AB_C:  cov_ab <= acc_res;
          agbkf_pkg::OP_BA_P,  agbkf_pkg::OP_BA_C:  cov_ba <= acc_res;
          agbkf_pkg::OP_BB_P,  agbkf_pkg::OP_BB_C:  cov_bb <= acc_res;
          agbkf_pkg::OP_BIAS_C:                     bias   <= acc_res;
          default: ;
        endcase
      end
    end
  end

  // Datapath registers without reset
  always_ff @(posedge clk) begin
    if (state == agbkf_pkg::ST_IDLE && in_valid) begin
      meas <= angle_meas;
      gyro <= gyro_rate;
      dt   <= time_step;
    end
    if (state == agbkf_pkg::ST_MUL) begin
      prod <= mul_a * mul_b;
    end
    if (state == agbkf_pkg::ST_DIV_SETUP) begin
      if (!div_sel) begin
        // capture innovation and pre-correction covariance once per beat
        e32 <= agbkf_pkg::sat32(SW'(meas) - SW'(angle));
        t0  <= cov_aa;
        t1  <= cov_ab;
      end
      div_rem <= '0;
      div_den <= 34'(var_s);
      div_dvd <= {num_mag, 30'd0};
      div_q   <= '0;
      div_neg <= div_num[31] && (var_s > 34'sd0);
    end
    if (state == agbkf_pkg::ST_DIV) begin
      if (div_r2 >= {1'b0, div_den}) begin
        div_rem <= 34'(div_r2 - {1'b0, div_den});
        div_q   <= {div_q[60:0], 1'b1};
      end else begin
        div_rem <= div_r2[33:0];
        div_q   <= {div_q[60:0], 1'b0};
      end
      div_dvd <= {div_dvd[60:0], 1'b0};
    end
    if (state == agbkf_pkg::ST_DIV_DONE) begin
      if (div_sel) k1 <= gain;
      else         k0 <= gain;
    end
    if (state == agbkf_pkg::ST_OUT && (!out_valid || !out_stall)) begin
      angle_est <= angle;
      rate_est  <= agbkf_pkg::sat32(SW'(gyro) - SW'(bias));
    end
  end

  `AGB_ASSERT(a_accept_starts, (in_valid && !in_stall) |=> (state == agbkf_pkg::ST_MUL && op == agbkf_pkg::OP_ANG_P), "accepted beat did not start the first step")
  `AGB_ASSERT(a_out_from_final, $rose(out_valid) |-> ($past(state) == agbkf_pkg::ST_OUT), "result shown outside the final state")
  `AGB_ASSERT(a_div_den_pos, (state == agbkf_pkg::ST_DIV) |-> (div_den != 34'd0 && !div_den[33]), "division with non-positive divisor")
  `AGB_ASSERT(a_div_cnt_range, div_cnt <= agbkf_pkg::CNT_W'(agbkf_pkg::DIV_STEPS), "divider count out of range")

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  localparam int N_RANDOM    = 1730;
  localparam int LATENCY     = 200;
  localparam int CYCLE_LIMIT = 1500000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // sample channel
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [24:0] angle_meas = '0;
  logic signed [27:0] gyro_rate = '0;
  logic [15:0]        time_step = '0;

  // estimate channel
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] angle_est;
  logic signed [31:0] rate_est;

  // register write channel
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = agbkf_pkg::REG_APN;
  logic [15:0] cfg_data = '0;

  always #10 clk = ~clk;

  angle_gyro_bias_kalman_filter dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .angle_meas(angle_meas), .gyro_rate(gyro_rate), .time_step(time_step),
    .out_valid(out_valid), .out_stall(out_stall),
    .angle_est(angle_est), .rate_est(rate_est),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  typedef struct packed {
    logic signed [24:0] meas;
    logic signed [27:0] gyro;
    logic [15:0]        dt;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] angle;
    logic signed [31:0] rate;
  } estimate_t;

  sample_t   pending_samples[$];
  estimate_t expected_estimates[$];

  // Filter state mirrored in the testbench.
  longint f_angle, f_bias, p_aa, p_ab, p_ba, p_bb;
  longint q_angle, q_bias, r_meas;

  int errors = 0;
  int n_sent = 0;
  int n_seen = 0;
  int n_stalled_in = 0;
  int cycle = 0;
  bit hold_off = 1'b0;

  function automatic longint clamp32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // Round half up: floor((x + 2^(s-1)) / 2^s); >>> on longint is a floor.
  function automatic longint rnd_shift(longint x, int s);
    return (x + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint gain(longint num, longint den);
    if (den <= 0) return 0;
    return clamp32((num * (64'sd1 <<< agbkf_pkg::COV_BITS)) / den);
  endfunction

  task automatic filter_reset();
    f_angle = 0; f_bias = 0;
    p_aa = 64'sd1 <<< agbkf_pkg::COV_BITS; p_ab = 0; p_ba = 0;
    p_bb = 64'sd1 <<< agbkf_pkg::COV_BITS;
    q_angle = longint'(agbkf_pkg::APN_RESET);
    q_bias = longint'(agbkf_pkg::BPN_RESET);
    r_meas = longint'(agbkf_pkg::MN_RESET);
  endtask

  // Advance the mirrored filter by one sample and queue the estimate.
  task automatic filter_update(sample_t s);
    longint meas, gyro, dt, qa, qb, rm, e, k0, k1, t0, t1, d_aa, d_off;
    estimate_t est;
    meas = longint'($signed(s.meas)); gyro = longint'($signed(s.gyro));
    dt = longint'(s.dt);
    qa = q_angle <<< agbkf_pkg::NOISE_SH;
    qb = q_bias <<< agbkf_pkg::NOISE_SH;
    rm = r_meas <<< agbkf_pkg::NOISE_SH;
    f_angle = clamp32(f_angle + rnd_shift((gyro - f_bias) * dt, agbkf_pkg::DT_BITS));
    e = clamp32(meas - f_angle);
    d_aa = qa - p_ab - p_ba;
    d_off = -p_bb;
    p_aa = clamp32(p_aa + rnd_shift(d_aa * dt, agbkf_pkg::DT_BITS));
    p_ab = clamp32(p_ab + rnd_shift(d_off * dt, agbkf_pkg::DT_BITS));
    p_ba = clamp32(p_ba + rnd_shift(d_off * dt, agbkf_pkg::DT_BITS));
    p_bb = clamp32(p_bb + rnd_shift(qb * dt, agbkf_pkg::DT_BITS));
    k0 = gain(p_aa, rm + p_aa);
    k1 = gain(p_ba, rm + p_aa);
    t0 = p_aa; t1 = p_ab;
    p_aa = clamp32(p_aa - rnd_shift(k0 * t0, agbkf_pkg::COV_BITS));
    p_ab = clamp32(p_ab - rnd_shift(k0 * t1, agbkf_pkg::COV_BITS));
    p_ba = clamp32(p_ba - rnd_shift(k1 * t0, agbkf_pkg::COV_BITS));
    p_bb = clamp32(p_bb - rnd_shift(k1 * t1, agbkf_pkg::COV_BITS));
    f_angle = clamp32(f_angle + rnd_shift(k0 * e, agbkf_pkg::COV_BITS));
    f_bias = clamp32(f_bias + rnd_shift(k1 * e, agbkf_pkg::COV_BITS));
    est.angle = f_angle[31:0];
    est.rate = 32'(clamp32(gyro - f_bias));
    expected_estimates.push_back(est);
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("estimate %0d: %s got %0d expected %0d", n_seen, what,
             $signed(got), $signed(want));
  endtask

  // Short gaps mostly, now and then a long one.
  function automatic int gap_len();
    if ($urandom_range(9, 0) < 4) return 0;
    if ($urandom_range(19, 0) == 0) return $urandom_range(60, 10);
    return $urandom_range(3, 1);
  endfunction

  function automatic sample_t random_sample(int kind);
    sample_t s;
    case (kind)
      // raw noise over the full field widths
      0: begin
        s.meas = 25'($urandom); s.gyro = 28'($urandom); s.dt = 16'($urandom);
      end
      // plausible IMU traffic: modest angles and rates, short time steps
      default: begin
        s.meas = 25'($signed($urandom_range(2 * 5898240, 0)) - 5898240);
        s.gyro = 28'($signed($urandom_range(2 * 6553600, 0)) - 6553600);
        s.dt = 16'($urandom_range(200, 0));
      end
    endcase
    return s;
  endfunction

  // Stall seen at the last rising edge, so the driver knows whether its beat left.
  logic in_stall_q = 1'b1;

  // Driver: present the next sample on the falling edge, hold it while stalled.
  int drv_gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall_q) begin
        // the previous beat was taken at the last rising edge
        drv_gap = gap_len();
      end
      if (in_valid && in_stall_q) begin
        // hold the stalled beat
      end else if (drv_gap > 0) begin
        drv_gap--;
        in_valid <= 1'b0;
      end else if (pending_samples.size() > 0) begin
        sample_t s;
        s = pending_samples.pop_front();
        angle_meas <= s.meas; gyro_rate <= s.gyro; time_step <= s.dt;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    in_stall_q <= in_stall;
    if (!rst && in_valid && !in_stall) begin
      filter_update({angle_meas, gyro_rate, time_step});
      n_sent++;
    end
    if (!rst && in_valid && in_stall) n_stalled_in++;
  end

  // Receiver stall pattern; a long hold-off can be forced from the stimulus.
  int stall_left = 0;
  always @(negedge clk) begin
    if (hold_off) begin
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      stall_left = gap_len();
      out_stall <= (stall_left > 0);
    end
  end

  // Monitor: compare each estimate against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      estimate_t want;
      if (expected_estimates.size() == 0) begin
        report("estimate with no sample behind it", angle_est, 32'd0);
      end else begin
        want = expected_estimates.pop_front();
        if (angle_est !== want.angle) report("angle_est", angle_est, want.angle);
        if (rate_est !== want.rate) report("rate_est", rate_est, want.rate);
      end
      n_seen++;
    end
  end

  always @(posedge clk) begin
    cycle++;
    if (cycle > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle);
      $display("angle_gyro_bias_kalman_filter: mismatch");
      $finish;
    end
  end

  task automatic drain();
    while (pending_samples.size() > 0 || in_valid || expected_estimates.size() > 0)
      @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  // Write one noise register; only called with the filter idle.
  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_index <= idx; cfg_data <= val; cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      agbkf_pkg::REG_APN: q_angle = longint'(val);
      agbkf_pkg::REG_BPN: q_bias = longint'(val);
      agbkf_pkg::REG_MN:  r_meas = longint'(val);
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_noise(logic [15:0] qa, logic [15:0] qb, logic [15:0] rm);
    write_reg(agbkf_pkg::REG_APN, qa);
    write_reg(agbkf_pkg::REG_BPN, qb);
    write_reg(agbkf_pkg::REG_MN, rm);
  endtask

  task automatic push(logic signed [24:0] m, logic signed [27:0] g, logic [15:0] d);
    sample_t s;
    s.meas = m; s.gyro = g; s.dt = d;
    pending_samples.push_back(s);
  endtask

  initial begin
    int n;
    filter_reset();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: field extremes at reset noise values.
    push(25'sd0, 28'sd0, 16'd0);
    push(25'sd11796480, 28'sd131072000, 16'd65535);
    push(-25'sd11796480, -28'sd131072000, 16'd65535);
    push(25'h0FFFFFF, 28'h7FFFFFF, 16'hFFFF);
    push(25'h1000000, 28'h8000000, 16'hFFFF);
    push(25'sd65536, 28'sd6553600, 16'd66);
    push(25'sd0, 28'sd0, 16'd1);
    push(-25'sd1, -28'sd1, 16'd0);
    drain();

    // Zero measurement noise with a covariance pushed negative: gains drop out.
    set_noise(16'd0, 16'd0, 16'd0);
    push(25'sd0, 28'sd0, 16'd0);
    push(25'sd1000, 28'h7FFFFFF, 16'hFFFF);
    push(25'sd5000, 28'h8000000, 16'hFFFF);
    for (int i = 0; i < 6; i++) push(25'h0FFFFFF, 28'h8000000, 16'hFFFF);
    drain();

    // Maximum noise everywhere; the state restarts from wherever it drifted.
    set_noise(16'hFFFF, 16'hFFFF, 16'hFFFF);
    for (int i = 0; i < 6; i++) push(25'h1000000, 28'h7FFFFFF, 16'hFFFF);
    drain();

    // Random phases across several noise settings, one with a long hold-off.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_noise(agbkf_pkg::APN_RESET, agbkf_pkg::BPN_RESET, agbkf_pkg::MN_RESET);
        1: set_noise(16'd1, 16'd0, 16'd1);
        5: set_noise(16'hFFFF, 16'hFFFF, 16'd1);
        default: set_noise(16'($urandom), 16'($urandom), 16'($urandom_range(65535, 1)));
      endcase
      n = N_RANDOM / 6;
      for (int i = 0; i < n; i++)
        pending_samples.push_back(random_sample($urandom_range(9, 0) < 2 ? 0 : 1));
      if (ph == 2) begin
        hold_off = 1'b1;
        repeat (2000) @(posedge clk);
        hold_off = 1'b0;
      end
      drain();
    end

    $display("sent %0d samples, checked %0d estimates, %0d stalled input cycles",
             n_sent, n_seen, n_stalled_in);
    $display("covered field extremes, zero and full-scale noise, saturation, random IMU data");
    if (errors == 0 && expected_estimates.size() == 0) begin
      $display("angle_gyro_bias_kalman_filter: match");
    end else begin
      $display("angle_gyro_bias_kalman_filter: mismatch");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/agbkf_pkg.sv
rtl/angle_gyro_bias_kalman_filter.sv
sim/testbench.sv
